@@ rtl/core/btu_pkg.sv @@
// ----------------------------------------------------------------------------
// btu_pkg
// shared types and constants for the block transfer unit register file
// ----------------------------------------------------------------------------
package btu_pkg;

  localparam int NUM_UNITS = 4;
  localparam int UNIT_W    = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

  localparam int ADDR_W  = 28;
  localparam int SIZE_W  = 20;
  localparam int CNT_W   = 16;
  localparam int STAT_W  = 3;
  localparam int FUNC_W  = 2;
  localparam int BLOCK_W = 3;
  localparam int LINE_W  = 5;
  localparam int DONE_W  = 4;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  // block and line codes
  localparam logic [BLOCK_W-1:0] COMMON_BLOCK = 3'd4;
  localparam logic [LINE_W-1:0]  LINE_SRC     = 5'd0;
  localparam logic [LINE_W-1:0]  LINE_DST     = 5'd1;
  localparam logic [LINE_W-1:0]  LINE_SIZE    = 5'd2;
  localparam logic [LINE_W-1:0]  LINE_STATUS  = 5'd3;
  localparam logic [LINE_W-1:0]  LINE_INHIBIT = 5'd0;
  localparam logic [LINE_W-1:0]  LINE_DONE    = 5'd1;

  // status bits, held as word bits 3:1
  localparam int ST_PDT = 0;
  localparam int ST_TC  = 1;
  localparam int ST_TIP = 2;

  typedef struct packed {
    logic [ADDR_W-1:0]  write_data;
    logic [LINE_W-1:0]  line;
    logic [BLOCK_W-1:0] block;
    logic [FUNC_W-1:0]  func;
  } btu_item_t;

  typedef struct packed {
    logic [DONE_W-1:0] complete_flags;
    logic [ADDR_W-1:0] read_data;
  } btu_result_t;

endpackage

@@ rtl/core/btu_regfile.sv @@
// ----------------------------------------------------------------------------
// btu_regfile
// unit and common registers, with read, write and service tick in one pass
// ----------------------------------------------------------------------------
module btu_regfile (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  btu_pkg::btu_item_t item,
  output btu_pkg::btu_result_t result
);
  import btu_pkg::*;

  logic [ADDR_W-1:0] source_addr [NUM_UNITS];
  logic [ADDR_W-1:0] dest_addr   [NUM_UNITS];
  logic [SIZE_W-1:0] size_word   [NUM_UNITS];
  logic [STAT_W-1:0] status_bits [NUM_UNITS];
  logic [NUM_UNITS-1:0] unit_armed;
  logic              inhibit_bit;
  logic [DONE_W-1:0] done_vector;

  logic [ADDR_W-1:0] source_addr_next [NUM_UNITS];
  logic [ADDR_W-1:0] dest_addr_next   [NUM_UNITS];
  logic [SIZE_W-1:0] size_word_next   [NUM_UNITS];
  logic [STAT_W-1:0] status_bits_next [NUM_UNITS];
  logic [NUM_UNITS-1:0] unit_armed_next;
  logic              inhibit_bit_next;
  logic [DONE_W-1:0] done_vector_next;

  logic              unit_hit;
  logic [UNIT_W-1:0] u;
  logic [CNT_W-1:0]  cnt;
  logic [7:0]        done_byte;
  logic [ADDR_W-1:0] rd;

  assign unit_hit = (item.block < BLOCK_W'(NUM_UNITS));
  assign u        = item.block[UNIT_W-1:0];
  assign cnt      = size_word[u][CNT_W-1:0];

  always_comb begin
    done_byte = '0;
    for (int i = 0; i < DONE_W; i++) begin
      done_byte[7-i] = done_vector[i];
    end
  end

  always_comb begin
    source_addr_next = source_addr;
    dest_addr_next   = dest_addr;
    size_word_next   = size_word;
    status_bits_next = status_bits;
    unit_armed_next  = unit_armed;
    inhibit_bit_next = inhibit_bit;
    done_vector_next = done_vector;
    rd               = '0;
    case (item.func)
      FUNC_READ: begin
        if (unit_hit) begin
          case (item.line)
            LINE_SRC:    rd = source_addr[u];
            LINE_DST:    rd = dest_addr[u];
            LINE_SIZE:   rd = ADDR_W'(size_word[u]);
            LINE_STATUS: rd = ADDR_W'({status_bits[u], 1'b0});
            default:     rd = '0;
          endcase
        end else if (item.block == COMMON_BLOCK) begin
          case (item.line)
            LINE_INHIBIT: rd = ADDR_W'(inhibit_bit);
            LINE_DONE:    rd = ADDR_W'(done_byte);
            default:      rd = '0;
          endcase
        end
      end
      FUNC_WRITE: begin
        if (unit_hit) begin
          case (item.line)
            LINE_SRC:  source_addr_next[u] = item.write_data;
            LINE_DST:  dest_addr_next[u]   = item.write_data;
            LINE_SIZE: size_word_next[u]   = item.write_data[SIZE_W-1:0];
            LINE_STATUS: begin
              status_bits_next[u] = item.write_data[STAT_W:1];
              if (!status_bits[u][ST_TIP] && item.write_data[ST_TIP+1]) begin
                unit_armed_next[u] = 1'b1;
              end
              done_vector_next[u] = item.write_data[ST_TC+1];
            end
            default: ;
          endcase
        end else if (item.block == COMMON_BLOCK && item.line == LINE_INHIBIT) begin
          inhibit_bit_next = item.write_data[0];
        end
      end
      FUNC_TICK: begin
        if (unit_hit && unit_armed[u]) begin
          if (status_bits[u][ST_TIP]) begin
            if (cnt == '0) begin
              status_bits_next[u][ST_TIP] = 1'b0;
              status_bits_next[u][ST_TC]  = 1'b1;
              done_vector_next[u]         = 1'b1;
              unit_armed_next[u]          = 1'b0;
            end
            size_word_next[u][CNT_W-1:0] = cnt - CNT_W'(2);
          end else begin
            status_bits_next[u][ST_TIP] = 1'b0;
            status_bits_next[u][ST_TC]  = 1'b1;
            done_vector_next[u]         = 1'b1;
            unit_armed_next[u]          = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign result.read_data      = rd;
  assign result.complete_flags = done_vector_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_UNITS; i++) begin
        source_addr[i] <= '0;
        dest_addr[i]   <= '0;
        size_word[i]   <= '0;
        status_bits[i] <= '0;
      end
      unit_armed  <= '0;
      inhibit_bit <= 1'b0;
      done_vector <= '0;
    end else if (en) begin
      source_addr <= source_addr_next;
      dest_addr   <= dest_addr_next;
      size_word   <= size_word_next;
      status_bits <= status_bits_next;
      unit_armed  <= unit_armed_next;
      inhibit_bit <= inhibit_bit_next;
      done_vector <= done_vector_next;
    end
  end

endmodule

@@ rtl/core/block_transfer_unit_registers_unit.sv @@
// ----------------------------------------------------------------------------
// block_transfer_unit_registers_unit
// four-unit block transfer register file behind stream ports
//
//   channel  dir  word
//   s_axis   in   register read, register write or service tick
//   m_axis   out  read data and per-unit complete flags, one per input word
//
// each word is held in the input register, then updates the registers and
// loads the output register; one word per cycle sustained while the output
// is not stalled, set by the single register file pass
// rst is synchronous and clears the register file and the valid flags of both stages
// a stalled output holds a pending word in the input register and drops s_axis_tready
// ----------------------------------------------------------------------------
module block_transfer_unit_registers_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // func[1:0], block[4:2], line[9:5], write_data[37:10], zero[39:38]
  input  logic [btu_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // read_data[27:0], complete_flags[31:28]
  output logic [btu_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import btu_pkg::*;

  logic        in_valid;
  btu_item_t   in_item;
  logic        advance;
  btu_result_t res;
  btu_result_t out_word;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= btu_item_t'(s_axis_tdata[$bits(btu_item_t)-1:0]);
    end
  end

  btu_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = out_word;

`ifndef NO_ASSERTIONS
  a_pending_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("pending word did not reach output");

  a_output_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_valid))
    else $error("output loaded with no pending word");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");
`endif

endmodule

@@ bench/btu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btu_checker
// watches both stream channels of the block transfer register file, keeps
// its own copy of every unit's registers, predicts the response to each
// accepted input word and compares it field by field with the output words
// ----------------------------------------------------------------------------
module btu_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [btu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [btu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output int                               fail_count,
  output int                               pending,
  output int                               checked
);
  import btu_pkg::*;

  logic [ADDR_W-1:0] src_addr   [NUM_UNITS];
  logic [ADDR_W-1:0] dst_addr   [NUM_UNITS];
  logic [SIZE_W-1:0] size_reg   [NUM_UNITS];
  logic [STAT_W-1:0] stat_reg   [NUM_UNITS];
  logic              armed      [NUM_UNITS];
  logic              inhibit;
  logic [DONE_W-1:0] done_flags;

  btu_result_t expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 20) begin
      $display("mismatch %0d at %0t ns: %s, got 0x%0h, expected 0x%0h",
               fail_count, $time, what, got, want);
    end
  endtask

  function automatic void finish_transfer(int u);
    stat_reg[u][ST_TIP] = 1'b0;
    stat_reg[u][ST_TC]  = 1'b1;
    done_flags[u]       = 1'b1;
    armed[u]            = 1'b0;
  endfunction

  function automatic btu_result_t apply_word(btu_item_t it);
    btu_result_t      r;
    int               u;
    logic             unit_hit;
    logic [CNT_W-1:0] cnt;
    r        = '0;
    u        = int'(it.block);
    unit_hit = (u < NUM_UNITS);
    case (it.func)
      FUNC_READ: begin
        if (unit_hit) begin
          case (it.line)
            LINE_SRC:    r.read_data = src_addr[u];
            LINE_DST:    r.read_data = dst_addr[u];
            LINE_SIZE:   r.read_data = ADDR_W'(size_reg[u]);
            LINE_STATUS: r.read_data = ADDR_W'({stat_reg[u], 1'b0});
            default: ;
          endcase
        end else if (it.block == COMMON_BLOCK) begin
          if (it.line == LINE_INHIBIT) begin
            r.read_data = ADDR_W'(inhibit);
          end else if (it.line == LINE_DONE) begin
            // unit n sits at bit 7-n
            r.read_data = ADDR_W'({done_flags[0], done_flags[1], done_flags[2],
                                   done_flags[3], 4'b0});
          end
        end
      end
      FUNC_WRITE: begin
        if (unit_hit) begin
          case (it.line)
            LINE_SRC:  src_addr[u] = it.write_data;
            LINE_DST:  dst_addr[u] = it.write_data;
            LINE_SIZE: size_reg[u] = it.write_data[SIZE_W-1:0];
            LINE_STATUS: begin
              if (!stat_reg[u][ST_TIP] && it.write_data[ST_TIP+1]) begin
                armed[u] = 1'b1;
              end
              stat_reg[u]   = it.write_data[STAT_W:1];
              done_flags[u] = it.write_data[ST_TC+1];
            end
            default: ;
          endcase
        end else if (it.block == COMMON_BLOCK && it.line == LINE_INHIBIT) begin
          inhibit = it.write_data[0];
        end
      end
      FUNC_TICK: begin
        if (unit_hit && armed[u]) begin
          if (stat_reg[u][ST_TIP]) begin
            cnt = size_reg[u][CNT_W-1:0];
            if (cnt == '0) begin
              finish_transfer(u);
            end
            size_reg[u][CNT_W-1:0] = cnt - CNT_W'(2);
          end else begin
            finish_transfer(u);
          end
        end
      end
      default: ;
    endcase
    r.complete_flags = done_flags;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    btu_item_t   it;
    btu_result_t got;
    btu_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_UNITS; i++) begin
        src_addr[i] = '0;
        dst_addr[i] = '0;
        size_reg[i] = '0;
        stat_reg[i] = '0;
        armed[i]    = 1'b0;
      end
      inhibit    = 1'b0;
      done_flags = '0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        it = s_axis_tdata[$bits(btu_item_t)-1:0];
        expected_results.push_back(apply_word(it));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("output word with nothing expected", m_axis_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data) begin
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
          end
          if (got.complete_flags !== want.complete_flags) begin
            report_mismatch("complete_flags", 32'(got.complete_flags),
                            32'(want.complete_flags));
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives register reads, writes and service ticks into the block transfer
// register file: a short directed list, then transfer sequences that program
// a unit, arm it and tick it to completion or abort it, mixed with random
// words; both stream sides stall at random in two of three idling mixes
// ----------------------------------------------------------------------------
module testbench;
  import btu_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam logic [ADDR_W-1:0] PDT_WORD  = 28'h2;
  localparam logic [ADDR_W-1:0] TC_WORD   = 28'h4;
  localparam logic [ADDR_W-1:0] TIP_WORD  = 28'h8;
  localparam logic [ADDR_W-1:0] ALL_ONES  = 28'hFFFFFFF;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tready = 1'b0;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int snd_idle_pct = 27;
  int rcv_idle_pct = 86;
  int n_read       = 0;
  int n_write      = 0;
  int n_tick       = 0;
  int n_other      = 0;
  int n_words      = 0;
  int n_transfers  = 0;
  int fail_count;
  int pending;
  int checked;

  block_transfer_unit_registers_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  btu_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic logic [ADDR_W-1:0] rand_word();
    return ADDR_W'($urandom);
  endfunction

  task automatic issue(input logic [FUNC_W-1:0] f, input logic [BLOCK_W-1:0] b,
                       input logic [LINE_W-1:0] l, input logic [ADDR_W-1:0] d);
    btu_item_t it;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    it.func       = f;
    it.block      = b;
    it.line       = l;
    it.write_data = d;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(it);
    do @(posedge clk); while (!s_axis_tready);
    n_words++;
    case (f)
      FUNC_READ:  n_read++;
      FUNC_WRITE: n_write++;
      FUNC_TICK:  n_tick++;
      default:    n_other++;
    endcase
  endtask

  // program one unit, arm it, then tick it down; odd counts never reach zero and
  // random counts rarely do, so those transfers are aborted by clearing tip
  task automatic run_transfer();
    logic [BLOCK_W-1:0] u;
    logic [CNT_W-1:0]   cnt;
    logic [ADDR_W-1:0]  d;
    int                 mode;
    int                 steps;
    u    = BLOCK_W'($urandom_range(NUM_UNITS - 1));
    mode = $urandom_range(9);
    if (mode < 6) begin
      cnt = CNT_W'(2 * $urandom_range(6));
    end else if (mode < 8) begin
      cnt = CNT_W'(2 * $urandom_range(6) + 1);
    end else begin
      cnt = CNT_W'($urandom);
    end
    if ($urandom_range(1)) issue(FUNC_WRITE, u, LINE_SRC, rand_word());
    if ($urandom_range(1)) issue(FUNC_WRITE, u, LINE_DST, rand_word());
    d = rand_word();
    d[CNT_W-1:0] = cnt;
    issue(FUNC_WRITE, u, LINE_SIZE, d);
    issue(FUNC_WRITE, u, LINE_STATUS, rand_word() | TIP_WORD);
    steps = (mode < 6) ? int'(cnt) / 2 + 1 + $urandom_range(2) : $urandom_range(1, 4);
    repeat (steps) begin
      if ($urandom_range(9) < 3) begin
        issue(FUNC_READ, u, LINE_W'($urandom_range(LINE_SIZE, LINE_STATUS)), rand_word());
      end
      issue(FUNC_TICK, u, LINE_W'($urandom), rand_word());
    end
    if (mode >= 6) begin
      issue(FUNC_WRITE, u, LINE_STATUS, rand_word() & ~TIP_WORD);
      issue(FUNC_TICK, u, LINE_W'($urandom), rand_word());
    end
    issue(FUNC_READ, COMMON_BLOCK, LINE_DONE, rand_word());
    n_transfers++;
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int words);
    int                 target;
    int                 r;
    logic [FUNC_W-1:0]  f;
    logic [BLOCK_W-1:0] b;
    logic [LINE_W-1:0]  l;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    target       = n_words + words;
    while (n_words < target) begin
      if ($urandom_range(99) < 55) begin
        run_transfer();
      end else begin
        r = $urandom_range(15);
        f = (r < 6) ? FUNC_READ : (r < 11) ? FUNC_WRITE : (r < 15) ? FUNC_TICK : FUNC_NONE;
        b = ($urandom_range(9) < 8) ? BLOCK_W'($urandom_range(4)) : BLOCK_W'($urandom_range(7));
        l = ($urandom_range(9) < 8) ? LINE_W'($urandom_range(3)) : LINE_W'($urandom_range(31));
        issue(f, b, l, rand_word());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register extremes, masking, unmapped space and unused function code
    issue(FUNC_READ,  3'd0, LINE_SRC, '0);
    issue(FUNC_WRITE, 3'd0, LINE_SRC, ALL_ONES);
    issue(FUNC_READ,  3'd0, LINE_SRC, '0);
    issue(FUNC_WRITE, 3'd3, LINE_DST, 28'hA5A5A5A);
    issue(FUNC_READ,  3'd3, LINE_DST, ALL_ONES);
    issue(FUNC_WRITE, 3'd1, LINE_SIZE, ALL_ONES);
    issue(FUNC_READ,  3'd1, LINE_SIZE, '0);
    issue(FUNC_WRITE, COMMON_BLOCK, LINE_INHIBIT, ALL_ONES);
    issue(FUNC_READ,  COMMON_BLOCK, LINE_INHIBIT, '0);
    issue(FUNC_WRITE, COMMON_BLOCK, LINE_DONE, ALL_ONES);
    issue(FUNC_READ,  3'd7, 5'd31, ALL_ONES);
    issue(FUNC_WRITE, 3'd5, LINE_SRC, ALL_ONES);
    issue(FUNC_READ,  3'd2, 5'd31, '0);
    issue(FUNC_NONE,  3'd0, LINE_SRC, ALL_ONES);
    issue(FUNC_TICK,  3'd0, LINE_SRC, '0);

    // armed with zero count completes on the first tick and wraps the count
    issue(FUNC_WRITE, 3'd2, LINE_STATUS, TIP_WORD);
    issue(FUNC_TICK,  3'd2, LINE_SRC, '0);
    issue(FUNC_READ,  3'd2, LINE_SIZE, '0);

    // nonzero count stays armed, then clearing tip completes on the next tick
    issue(FUNC_WRITE, 3'd1, LINE_STATUS, TIP_WORD | TC_WORD | PDT_WORD);
    issue(FUNC_TICK,  3'd1, LINE_SRC, '0);
    issue(FUNC_WRITE, 3'd1, LINE_STATUS, PDT_WORD);
    issue(FUNC_TICK,  3'd1, LINE_SRC, '0);
    issue(FUNC_READ,  3'd1, LINE_STATUS, '0);
    issue(FUNC_READ,  COMMON_BLOCK, LINE_DONE, '0);
    issue(FUNC_TICK,  3'd6, LINE_SRC, ALL_ONES);

    run_phase(27, 86, 530);
    run_phase(86, 27, 530);
    run_phase(0, 0, 540);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d words: %0d reads, %0d writes, %0d ticks, %0d unused codes",
             n_words, n_read, n_write, n_tick, n_other);
    $display("%0d transfer sequences, %0d output words checked", n_transfers, checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout with %0d words still expected", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
